// ===== src/byte_stream_reassembler_macros.svh =====
// ----------------------------------------------------------------------------
// Byte stream reassembler assertion macros
// Shared forms for the concurrent checks on the reassembler ports.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_REASSEMBLER_MACROS_SVH
`define BYTE_STREAM_REASSEMBLER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BSR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte stream reassembler package
// Sizes, slot and cell control types, and sequencer states.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int WINDOW = 64;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int IDX_W  = 64;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } bsr_slot_t;

    typedef struct packed {
        logic shift;
        logic load;
    } bsr_cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } bsr_state_t;

endpackage

// ===== src/byte_stream_reassembler.sv =====
// An accepted item moves the sequencer from idle to run; its results are then registered in turn.
// No new item is taken until the last result of the current one is registered,
// as the window chain shifts one byte towards the output per cycle while the output is free.
// The result register frees the input side while the last result waits.
// Reset (aresetn low, synchronous) empties every cell, zeroes the counters,
// clears the end and closed flags; byte storage keeps its contents.
// ----------------------------------------------------------------------------
// Byte stream reassembler
// Stores out-of-order bytes in a chain of cells aligned to the next expected
// index and drains the in-order run one byte per cycle while the output is free.
// ----------------------------------------------------------------------------
module byte_stream_reassembler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [63:0] stream_index, [71:64] byte_value, [78:72] free_capacity, [79] zero
    input  logic [79:0] s_tdata,
    // [0] byte_present
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte, [14:8] pending_bytes, [15] zero
    output logic [15:0] m_tdata,
    // [0] out_valid, [1] stream_closed
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import bsr_pkg::*;

    bsr_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  next_exp_reg, next_exp_next;
    logic [IDX_W-1:0]  end_pos_reg, end_pos_next;
    logic              end_seen_reg, end_seen_next;
    logic              closed_reg, closed_next;
    logic [CNT_W-1:0]  held_reg, held_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    bsr_slot_t         slots [WINDOW];
    bsr_slot_t         nbrs  [WINDOW];
    bsr_cell_ctrl_t    cell_ctrl [WINDOW];

    logic [IDX_W-1:0]  in_idx;
    logic [BYTE_W-1:0] in_byte;
    logic [CNT_W-1:0]  in_cap;
    logic [CNT_W-1:0]  cap_sat;
    logic [IDX_W-1:0]  diff;
    logic              accept;
    logic              store;
    logic [SLOT_W-1:0] wr_idx;
    logic              out_free;
    logic              step;
    logic              drain;
    logic [IDX_W-1:0]  next_cand;
    logic              closed_after;
    logic              last_res;

    assign in_idx  = s_tdata[63:0];
    assign in_byte = s_tdata[71:64];
    assign in_cap  = s_tdata[78:72];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign step     = (state_reg == ST_RUN) && out_free;
    assign drain    = step && slots[0].valid;

    always_comb begin
        cap_sat = (in_cap > CNT_W'(WINDOW)) ? CNT_W'(WINDOW) : in_cap;
        diff    = in_idx - next_exp_reg;
        wr_idx  = diff[SLOT_W-1:0];
        // Window test on the difference, so the top of the index space never wraps.
        store   = accept && s_tuser[0] && !closed_reg && (in_idx >= next_exp_reg)
                  && (diff < IDX_W'(cap_sat));
        next_cand    = next_exp_reg + IDX_W'(slots[0].valid);
        closed_after = closed_reg || (end_seen_reg && (next_cand == end_pos_reg));
        last_res     = !slots[0].valid || !slots[1].valid;
    end

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        if (i == WINDOW - 1) begin : g_top
            assign nbrs[i] = '0;
        end else begin : g_mid
            assign nbrs[i] = slots[i+1];
        end
        assign cell_ctrl[i].shift = drain;
        assign cell_ctrl[i].load  = store && (wr_idx == SLOT_W'(i));

        bsr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl[i]),
            .wr_byte  (in_byte),
            .nbr_in   (nbrs[i]),
            .slot_out (slots[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        next_exp_next = next_exp_reg;
        end_pos_next  = end_pos_reg;
        end_seen_next = end_seen_reg;
        closed_next   = closed_reg;
        held_next     = held_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tlast) begin
                        end_seen_next = 1'b1;
                        end_pos_next  = in_idx + IDX_W'(s_tuser[0]);
                    end
                    if (store && !slots[wr_idx].valid) begin
                        held_next = held_reg + CNT_W'(1);
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step) begin
                    logic [CNT_W-1:0] held_out;
                    held_out = slots[0].valid ? held_reg - CNT_W'(1) : held_reg;
                    held_next     = held_out;
                    next_exp_next = next_cand;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, held_out,
                                     slots[0].valid ? slots[0].data : '0};
                    // Only the final result of an item reports the updated closed state.
                    m_tuser_next  = {last_res ? closed_after : closed_reg, slots[0].valid};
                    m_tlast_next  = last_res;
                    if (last_res) begin
                        closed_next = closed_after;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            next_exp_reg <= '0;
            end_pos_reg  <= '0;
            end_seen_reg <= 1'b0;
            closed_reg   <= 1'b0;
            held_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            next_exp_reg <= next_exp_next;
            end_pos_reg  <= end_pos_next;
            end_seen_reg <= end_seen_next;
            closed_reg   <= closed_next;
            held_reg     <= held_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== src/bsr_cell.sv =====
// ----------------------------------------------------------------------------
// Reassembler cell
// One slot of the reorder window: a byte and its valid flag. On a shift the
// cell takes its upper neighbour's contents, on a load it takes a new byte.
// ----------------------------------------------------------------------------
module bsr_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bsr_pkg::bsr_cell_ctrl_t ctrl,
    input  logic [7:0]             wr_byte,
    input  bsr_pkg::bsr_slot_t     nbr_in,
    output bsr_pkg::bsr_slot_t     slot_out
);
    import bsr_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= nbr_in.valid;
        end else if (ctrl.load) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            data_reg <= nbr_in.data;
        end else if (ctrl.load) begin
            data_reg <= wr_byte;
        end
    end

    assign slot_out.valid = valid_reg;
    assign slot_out.data  = data_reg;

endmodule

// ===== src/bsr_checker.sv =====
// ----------------------------------------------------------------------------
// Byte stream reassembler checker
// Port-level checks on result ordering, input stalling and the closed flag.
// ----------------------------------------------------------------------------
`include "byte_stream_reassembler_macros.svh"

module bsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [79:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    logic s_fire;
    logic m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // A result that is held back keeps its value.
    `BSR_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // A new item is not taken straight after one has been taken.
    `BSR_ASSERT_NEXT(a_one_item, aclk, aresetn, s_fire, !s_tready, "input taken twice in a row")

    // While an item's run of results is unfinished, the input stays closed.
    `BSR_ASSERT_SAME(a_run_blocks, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "input open mid-run")

    // A result without a byte is the only result of its item and carries a zero byte.
    `BSR_ASSERT_SAME(a_empty_res, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast && (m_tdata[7:0] == 8'h00), "malformed empty result")

    // Once reported closed, the stream stays closed.
    `BSR_ASSERT_NEXT(a_closed_sticky, aclk, aresetn, m_fire && m_tlast && m_tuser[1], !m_tvalid || m_tuser[1], "closed flag dropped")

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (.*);

// ===== tb/reassembly_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reassembly checker
// Watches both streams of the byte stream reassembler, works out the in-order
// releases that each accepted item should cause and compares every accepted
// result with the oldest one still awaited.
// ----------------------------------------------------------------------------
module reassembly_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [63:0] stream_index, [71:64] byte_value, [78:72] free_capacity, [79] zero
    input  logic [79:0] s_tdata,
    // [0] byte_present
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte, [14:8] pending_bytes, [15] zero
    input  logic [15:0] m_tdata,
    // [0] out_valid, [1] stream_closed
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          awaited_count,
    output int          bytes_released,
    output int          longest_run
);
    import bsr_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              carries;
        logic              closed;
        logic [CNT_W-1:0]  pending;
        logic              last;
    } release_t;

    release_t          awaited_releases[$];
    logic [BYTE_W-1:0] ring_data [WINDOW];
    logic              ring_held [WINDOW];
    logic [IDX_W-1:0]  next_pos;
    logic [IDX_W-1:0]  end_pos;
    logic              end_known;
    logic              shut;
    logic [CNT_W-1:0]  held;
    int                mismatches = 0;
    int                released   = 0;
    int                run_max    = 0;

    function automatic void clear_model();
        for (int k = 0; k < WINDOW; k++) begin
            ring_held[k] = 1'b0;
        end
        next_pos  = '0;
        end_pos   = '0;
        end_known = 1'b0;
        shut      = 1'b0;
        held      = '0;
    endfunction

    function automatic void predict_reassembly(input logic [IDX_W-1:0] pos,
                                               input logic [BYTE_W-1:0] value,
                                               input logic present,
                                               input logic ends,
                                               input logic [CNT_W-1:0] room);
        logic [IDX_W-1:0] reach;
        logic             was_shut;
        int               slot;
        int               run;
        release_t         r;
        reach    = (room > WINDOW) ? IDX_W'(WINDOW) : IDX_W'(room);
        was_shut = shut;
        run      = 0;
        if (ends) begin
            end_known = 1'b1;
            end_pos   = pos + IDX_W'(present);
        end
        // The window test is taken as a difference, so it never wraps.
        if (present && !shut && pos >= next_pos && pos - next_pos < reach) begin
            slot = int'(pos % IDX_W'(WINDOW));
            if (!ring_held[slot]) begin
                ring_held[slot] = 1'b1;
                held++;
            end
            ring_data[slot] = value;
        end
        while (run < WINDOW && ring_held[int'(next_pos % IDX_W'(WINDOW))]) begin
            slot = int'(next_pos % IDX_W'(WINDOW));
            ring_held[slot] = 1'b0;
            if (held != 0) begin
                held--;
            end
            next_pos++;
            r = '{data: ring_data[slot], carries: 1'b1, closed: was_shut,
                  pending: held, last: 1'b0};
            awaited_releases.push_back(r);
            run++;
        end
        if (end_known && next_pos == end_pos) begin
            shut = 1'b1;
        end
        // Only the final result of an item shows the closed state after it.
        if (run == 0) begin
            r = '{data: '0, carries: 1'b0, closed: shut, pending: held, last: 1'b1};
            awaited_releases.push_back(r);
        end else begin
            awaited_releases[awaited_releases.size() - 1].closed = shut;
            awaited_releases[awaited_releases.size() - 1].last   = 1'b1;
        end
        released += run;
        if (run > run_max) begin
            run_max = run;
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 40) begin
            $display("%0t ns  mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, %0h awaited", name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        release_t want;
        if (!aresetn) begin
            clear_model();
            awaited_releases.delete();
        end else begin
            // A result at this edge belongs to an item taken at an earlier one.
            if (m_tvalid && m_tready) begin
                if (awaited_releases.size() == 0) begin
                    report_mismatch($sformatf("result with nothing awaited, tdata %h tuser %b",
                                              m_tdata, m_tuser));
                end else begin
                    want = awaited_releases.pop_front();
                    compare_field("out_byte", m_tdata[7:0], want.data);
                    compare_field("out_valid", 8'(m_tuser[0]), 8'(want.carries));
                    compare_field("stream_closed", 8'(m_tuser[1]), 8'(want.closed));
                    compare_field("pending_bytes", 8'(m_tdata[14:8]), 8'(want.pending));
                    compare_field("last_of_run", 8'(m_tlast), 8'(want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                predict_reassembly(s_tdata[63:0], s_tdata[71:64], s_tuser[0], s_tlast,
                                   s_tdata[78:72]);
            end
        end
        mismatch_count <= mismatches;
        awaited_count  <= awaited_releases.size();
        bytes_released <= released;
        longest_run    <= run_max;
    end

endmodule

// ===== tb/byte_stream_reassembler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte stream reassembler regression
// Sends directed and random stream bytes, mostly well-formed runs shuffled out
// of order with noise between them, under random stalls on both streams, and
// finishes by closing the stream. The checker beside the block does the work
// of prediction and comparison.
// ----------------------------------------------------------------------------
module byte_stream_reassembler_test;
    import bsr_pkg::*;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int awaited_count;
    int bytes_released;
    int longest_run;

    // Where the stream stands after every item sent, and bytes held ahead of it.
    logic [IDX_W-1:0] stream_pos = '0;
    bit               ahead_held [bit [IDX_W-1:0]];
    int               items_sent    = 0;
    int               tx_idle_pct   = 25;
    int               rx_stall_pct  = 20;
    int               rx_stall_left = 0;

    byte_stream_reassembler uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    reassembly_checker release_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count),
        .bytes_released (bytes_released),
        .longest_run    (longest_run)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("byte_stream_reassembler regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (rx_stall_left > 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if ($urandom_range(99) < rx_stall_pct) begin
            m_tready      <= 1'b0;
            rx_stall_left <= $urandom_range(4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void track_item(input logic [IDX_W-1:0] pos, input logic present,
                                       input logic [CNT_W-1:0] room);
        logic [IDX_W-1:0] reach;
        reach = (room > WINDOW) ? IDX_W'(WINDOW) : IDX_W'(room);
        if (present && pos >= stream_pos && pos - stream_pos < reach) begin
            ahead_held[pos] = 1'b1;
        end
        while (ahead_held.exists(stream_pos)) begin
            ahead_held.delete(stream_pos);
            stream_pos++;
        end
    endfunction

    task automatic send_item(input logic [IDX_W-1:0] pos, input logic [BYTE_W-1:0] value,
                             input logic present, input logic stream_end,
                             input logic [CNT_W-1:0] room);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, room, value, pos};
        s_tuser  <= present;
        s_tlast  <= stream_end;
        do @(posedge aclk); while (!s_tready);
        track_item(pos, present, room);
        items_sent++;
    endtask

    task automatic send_byte(input logic [IDX_W-1:0] pos, input logic [BYTE_W-1:0] value,
                             input logic [CNT_W-1:0] room);
        send_item(pos, value, 1'b1, 1'b0, room);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_count != 0);
    endtask

    // An end index far beyond reach, so that the stream does not close early.
    task automatic send_far_end();
        send_item({1'b1, 31'($urandom), $urandom}, 8'($urandom), 1'($urandom), 1'b1,
                  CNT_W'($urandom_range(127)));
    endtask

    // Every index of a run from the current position, shuffled or descending.
    task automatic send_run(input int len, input bit descending);
        logic [IDX_W-1:0] order[$];
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] spare;
        logic [IDX_W-1:0] need;
        logic [CNT_W-1:0] room;
        int               j;
        base = stream_pos;
        for (int k = 0; k < len; k++) begin
            if (descending) begin
                order.push_front(base + IDX_W'(k));
            end else begin
                order.push_back(base + IDX_W'(k));
            end
        end
        if (!descending) begin
            for (int k = len - 1; k > 0; k--) begin
                j        = $urandom_range(k);
                spare    = order[k];
                order[k] = order[j];
                order[j] = spare;
            end
            if ($urandom_range(3) == 0) begin
                order.insert($urandom_range(order.size() - 1),
                             base + IDX_W'($urandom_range(len - 1)));
            end
        end
        foreach (order[k]) begin
            if (order[k] >= stream_pos) begin
                // Sometimes the window ends exactly at this byte.
                need = order[k] - stream_pos + 1;
                room = ($urandom_range(3) == 0) ? CNT_W'(need)
                                                : CNT_W'($urandom_range(127, int'(need)));
            end else begin
                room = CNT_W'($urandom_range(127));
            end
            send_byte(order[k], 8'($urandom), room);
        end
    endtask

    task automatic send_noise();
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] room;
        int               k;
        room = CNT_W'($urandom_range(127));
        case ($urandom_range(5))
            0: begin
                pos = (stream_pos != 0) ? {$urandom, $urandom} % stream_pos : '0;
                send_byte(pos, 8'($urandom), room);
            end
            1: send_item({$urandom, $urandom}, 8'($urandom), 1'($urandom), 1'b0, room);
            2: begin
                pos = stream_pos + ((room > WINDOW) ? IDX_W'(WINDOW) : IDX_W'(room));
                send_byte(pos, 8'($urandom), room);
            end
            3: begin
                k = $urandom_range(1, WINDOW - 1);
                send_byte(stream_pos + IDX_W'(k), 8'($urandom),
                          CNT_W'($urandom_range(127, k + 1)));
            end
            4: send_item(stream_pos + IDX_W'($urandom_range(3)), 8'($urandom), 1'b0, 1'b0,
                         room);
            default: send_byte(stream_pos, 8'($urandom), '0);
        endcase
    endtask

    task automatic random_phase(input int target);
        int pick;
        while (items_sent < target) begin
            tx_idle_pct  = 25 * $urandom_range(2);
            rx_stall_pct <= 20 * $urandom_range(2);
            pick = $urandom_range(99);
            if (pick < 58) begin
                send_run($urandom_range(1, 8), 1'b0);
            end else if (pick < 61) begin
                send_run($urandom_range(17, WINDOW), 1'b1);
            end else if (pick < 90) begin
                send_noise();
            end else begin
                send_far_end();
            end
        end
    endtask

    initial begin
        logic [IDX_W-1:0] base;
        bit [IDX_W-1:0]   far_pos;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_byte(64'd1, 8'h11, 7'd64);
        send_byte(64'd0, 8'h00, 7'd1);
        send_byte(64'd7, 8'h77, 7'd5);        // first index past a five-byte window
        send_byte(64'd6, 8'h66, 7'd5);
        send_byte(64'd3, 8'hAA, 7'd127);
        send_byte(64'd3, 8'h55, 7'd127);      // overwrites the byte held at 3
        send_byte(64'd66, 8'hEE, 7'd127);     // outside once capacity saturates
        send_byte(64'd65, 8'hDD, 7'd100);
        send_byte(64'd0, 8'hFF, 7'd64);       // already delivered
        send_byte(64'd2, 8'h22, 7'd0);
        send_item(64'd2, 8'h22, 1'b0, 1'b0, 7'd64);
        send_item('1, 8'hFF, 1'b1, 1'b1, 7'd127); // end index wraps round to zero
        send_item(64'h8000_0000_0000_0000, 8'h00, 1'b0, 1'b1, 7'd64);
        send_byte(64'd4, 8'h44, 7'd64);
        send_byte(64'd5, 8'h5A, 7'd64);
        send_byte(64'd2, 8'hFF, 7'd64);

        random_phase(110);
        wait_drained();
        send_run(WINDOW, 1'b1);
        random_phase(215);

        // Quiet finish: deliver whatever is held, then close the stream.
        tx_idle_pct  = 0;
        rx_stall_pct <= 0;
        if (ahead_held.size() > 0) begin
            void'(ahead_held.last(far_pos));
            while (stream_pos <= far_pos) begin
                send_byte(stream_pos, 8'($urandom), CNT_W'(WINDOW));
            end
        end
        base = stream_pos;
        send_item(base + 3, 8'h00, 1'b0, 1'b1, CNT_W'(WINDOW));
        send_byte(base + 2, 8'($urandom), CNT_W'(WINDOW));
        send_byte(base + 1, 8'($urandom), CNT_W'(WINDOW));
        send_byte(base, 8'($urandom), CNT_W'(WINDOW));
        // Data after the close is dropped; end flags still move the end index.
        send_byte(base + 3, 8'($urandom), CNT_W'(WINDOW));
        send_far_end();
        send_item(base + 3, 8'($urandom), 1'b0, 1'b1, CNT_W'(WINDOW));

        wait_drained();
        repeat (80) @(posedge aclk);
        $display("Summary: %0d items sent, %0d bytes released in order, longest release %0d.",
                 items_sent, bytes_released, longest_run);
        $display("Covered window edges, overwrites, end markers, a full window and the close.");
        if (mismatch_count == 0 && awaited_count == 0) begin
            $display("byte_stream_reassembler regression: pass");
        end else begin
            $display("byte_stream_reassembler regression: fail");
        end
        $finish;
    end

endmodule

// ===== byte_stream_reassembler.f =====
+incdir+src
src/bsr_pkg.sv
src/bsr_cell.sv
src/byte_stream_reassembler.sv
src/bsr_checker.sv
tb/reassembly_checker.sv
tb/byte_stream_reassembler_test.sv
